>>> rtl/fed_pkg.sv
// shared types and constants for the exact float to decimal digit block
`timescale 1ns / 1ps

package fed_pkg;

  // fixed-point layout of the placed value
  localparam int INT_BITS   = 128;
  localparam int FRAC_BITS  = 160;
  localparam int INT_DIGITS = 40;
  localparam int BCD_BITS   = 4 * INT_DIGITS;

  // widths of counters and result fields
  localparam int DIGIT_CNT_W = 6;
  localparam int DAB_STEP_W  = 7;
  localparam int COUNT_W     = 3;
  localparam int LZC_W       = 6;
  localparam int GROUP_BITS  = 16;
  localparam int PAYLOAD_W   = 23;

  // defaults for the top level parameters
  localparam int MAX_FRAC_DIGITS_DEF   = 50;
  localparam int DIGITS_PER_RESULT_DEF = 4;

  // result kinds
  typedef enum logic [1:0] {
    KIND_INT  = 2'd0,
    KIND_FRAC = 2'd1,
    KIND_INF  = 2'd2,
    KIND_NAN  = 2'd3
  } kind_t;

  // command and status of the binary to bcd converter
  typedef struct packed {
    logic                  start;
    logic [DAB_STEP_W-1:0] steps;
  } dab_cmd_t;

  typedef struct packed {
    logic                   busy;
    logic [DIGIT_CNT_W-1:0] total;
  } dab_stat_t;

  // command of the fraction times-ten unit
  typedef struct packed {
    logic load;
    logic step;
  } frac_cmd_t;

endpackage

>>> rtl/fed_dabble.sv
// shift-and-add-3 converter of the integer part, two bits per cycle
`timescale 1ns / 1ps

module fed_dabble (
  input  logic                            clk,
  input  logic                            rst,
  input  fed_pkg::dab_cmd_t               cmd,
  input  logic [fed_pkg::INT_BITS-1:0]    bin_init,
  output fed_pkg::dab_stat_t              stat,
  output logic [fed_pkg::BCD_BITS-1:0]    bcd
);

  logic [fed_pkg::INT_BITS-1:0]    bin;
  logic [fed_pkg::INT_DIGITS-1:0]  mask;
  logic [fed_pkg::DAB_STEP_W-1:0]  cnt;
  logic [fed_pkg::DIGIT_CNT_W-1:0] total;

  logic [fed_pkg::BCD_BITS-1:0]    bcd_half;
  logic [fed_pkg::BCD_BITS-1:0]    bcd_next;
  logic [fed_pkg::INT_DIGITS-1:0]  nz;
  logic [fed_pkg::INT_DIGITS-1:0]  mask_next;

  // one add-3 round over all digits, then shift in one bit
  function automatic logic [fed_pkg::BCD_BITS-1:0] dab_round(
    input logic [fed_pkg::BCD_BITS-1:0] v,
    input logic                         b
  );
    logic [fed_pkg::BCD_BITS-1:0] t;
    logic [3:0]                   nib;
    t = v;
    for (int k = 0; k < fed_pkg::INT_DIGITS; k++) begin
      nib = v[4*k +: 4];
      if (nib >= 4'd5) begin
        nib = nib + 4'd3;
      end
      t[4*k +: 4] = nib;
    end
    return {t[fed_pkg::BCD_BITS-2:0], b};
  endfunction

  // two bits per step; a step adds at most one decimal digit
  always_comb begin
    bcd_half = dab_round(bcd, bin[fed_pkg::INT_BITS-1]);
    bcd_next = dab_round(bcd_half, bin[fed_pkg::INT_BITS-2]);
    for (int k = 0; k < fed_pkg::INT_DIGITS; k++) begin
      nz[k] = |bcd_next[4*k +: 4];
    end
    mask_next = mask | ({mask[fed_pkg::INT_DIGITS-2:0], 1'b0} & nz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      total <= fed_pkg::DIGIT_CNT_W'(1);
      mask  <= fed_pkg::INT_DIGITS'(1);
    end else if (cmd.start) begin
      cnt   <= cmd.steps;
      total <= fed_pkg::DIGIT_CNT_W'(1);
      mask  <= fed_pkg::INT_DIGITS'(1);
    end else if (cnt != '0) begin
      cnt   <= cnt - 1'b1;
      mask  <= mask_next;
      if (|(mask_next & ~mask)) begin
        total <= total + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bin <= bin_init;
      bcd <= '0;
    end else if (cnt != '0) begin
      bin <= {bin[fed_pkg::INT_BITS-3:0], 2'b00};
      bcd <= bcd_next;
    end
  end

  assign stat.busy  = (cnt != '0);
  assign stat.total = total;

endmodule

>>> rtl/fed_frac_unit.sv
// fraction register with the shared times-ten adder, one digit per step
`timescale 1ns / 1ps

module fed_frac_unit (
  input  logic                          clk,
  input  fed_pkg::frac_cmd_t            cmd,
  input  logic [fed_pkg::FRAC_BITS-1:0] frac_init,
  output logic [3:0]                    digit
);

  logic [fed_pkg::FRAC_BITS-1:0] frac;
  logic [fed_pkg::FRAC_BITS+3:0] prod;

  // x*10 as x*8 + x*2; the bits above the fraction are the digit
  always_comb begin
    prod  = {1'b0, frac, 3'b000} + {3'b000, frac, 1'b0};
    digit = prod[fed_pkg::FRAC_BITS +: 4];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frac <= frac_init;
    end else if (cmd.step) begin
      frac <= prod[fed_pkg::FRAC_BITS-1:0];
    end
  end

endmodule

>>> rtl/float_to_exact_decimal_digits.sv
// top level: exact decimal digits of a binary32 magnitude, with sequencer
//
// channel  dir  tdata fields (low bit up)                          side
// s_*      in   float_bits[31:0] precision[39:32] lead_zero_valid[40] -
// m_*      out  digit_group[15:0] digit_count[18:16] nan_payload[41:19]
//               lead_zero_count[47:42]                        tuser=kind, tlast=last
//
// one item at a time; s_tready is high only while the sequencer is idle
// per item: setup, then converter steps of two integer bits each, an align step,
// one output per integer group, and one times-ten step per fraction digit
// (at most MAX_FRAC_DIGITS); the sequencer stalls when it has a result to load
// while the output register holds an untaken item; rst is synchronous and
// clears control state
`timescale 1ns / 1ps

module float_to_exact_decimal_digits #(
  parameter int MAX_FRAC_DIGITS   = fed_pkg::MAX_FRAC_DIGITS_DEF,
  parameter int DIGITS_PER_RESULT = fed_pkg::DIGITS_PER_RESULT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // float_bits, precision, lead_zero_valid
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // digit_group, digit_count, nan_payload, lead_zero_count
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast
);

  localparam int STEP_W = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int GRP_BITS = 4 * DIGITS_PER_RESULT;
  localparam logic [fed_pkg::GROUP_BITS-1:0] GMASK =
    fed_pkg::GROUP_BITS'({fed_pkg::GROUP_BITS{1'b1}} << (fed_pkg::GROUP_BITS - GRP_BITS));
  localparam logic [fed_pkg::COUNT_W-1:0] P_CNT = fed_pkg::COUNT_W'(DIGITS_PER_RESULT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_CONV,
    S_INT,
    S_FRAC
  } state_t;

  state_t state;

  // latched input item
  logic [31:0] in_bits;
  logic [7:0]  in_prec;
  logic        in_lzv;

  // fraction loop state
  logic [7:0]                      prec_left;
  logic                            zv;
  logic [fed_pkg::LZC_W-1:0]       skip;
  logic [STEP_W-1:0]               step;
  logic [fed_pkg::GROUP_BITS-1:0]  grp;
  logic [fed_pkg::COUNT_W-1:0]     gcnt;

  // integer emission state
  logic [fed_pkg::BCD_BITS-1:0]    emit;
  logic [fed_pkg::DIGIT_CNT_W-1:0] rem;

  // unit connections
  fed_pkg::dab_cmd_t               dcmd;
  fed_pkg::dab_stat_t              dstat;
  fed_pkg::frac_cmd_t              fcmd;
  logic [fed_pkg::INT_BITS-1:0]    bin_init;
  logic [fed_pkg::BCD_BITS-1:0]    dab_bcd;
  logic [fed_pkg::FRAC_BITS-1:0]   frac_init;
  logic [3:0]                      fdigit;

  // setup decode
  logic [7:0]                      expf;
  logic [22:0]                     mant_f;
  logic [23:0]                     mant24;
  logic [8:0]                      sh;
  logic [8:0]                      nbits;
  logic                            int_nz;
  logic                            is_special;
  logic [287:0]                    placed;

  // emission and loop helpers
  logic                            out_free;
  logic                            out_load;
  logic [fed_pkg::DIGIT_CNT_W-1:0] align_dig;
  logic [fed_pkg::BCD_BITS-1:0]    aligned;
  logic [fed_pkg::COUNT_W-1:0]     int_cnt;
  logic                            int_fin;
  logic                            counted;
  logic                            ends;
  logic                            emit_now;
  logic                            fstep;
  logic [3:0]                      gshift;
  logic [fed_pkg::GROUP_BITS-1:0]  newgrp;
  logic [7:0]                      prec_next;
  logic [fed_pkg::LZC_W-1:0]       skip_next;

  // placement of the mantissa: lsb lands at bit exp - 23 + 160
  always_comb begin
    expf       = in_bits[30:23];
    mant_f     = in_bits[22:0];
    is_special = (expf == 8'hFF);
    if (expf == 8'd0) begin
      mant24 = {1'b0, mant_f};
      sh     = 9'd11;
    end else begin
      mant24 = {1'b1, mant_f};
      sh     = {1'b0, expf} + 9'd10;
    end
    int_nz = (sh > 9'd136);
    nbits  = sh - 9'd136;
    placed = {264'd0, mant24} << sh;
    frac_init = placed[fed_pkg::FRAC_BITS-1:0];
    // integer part left aligned to an even bit count
    if (nbits[0]) begin
      bin_init = {1'b0, mant24, 103'd0};
    end else begin
      bin_init = {mant24, 104'd0};
    end
    dcmd.start = (state == S_SETUP) && !is_special;
    dcmd.steps = int_nz ? fed_pkg::DAB_STEP_W'((nbits + 9'd1) >> 1) : '0;
  end

  // integer group selection
  always_comb begin
    out_free  = !m_tvalid || m_tready;
    align_dig = fed_pkg::DIGIT_CNT_W'(fed_pkg::INT_DIGITS) - dstat.total;
    aligned   = dab_bcd << {align_dig, 2'b00};
    int_cnt   = (rem < fed_pkg::DIGIT_CNT_W'(DIGITS_PER_RESULT)) ?
                fed_pkg::COUNT_W'(rem) : P_CNT;
    int_fin   = (rem <= fed_pkg::DIGIT_CNT_W'(DIGITS_PER_RESULT));
  end

  // one fraction digit
  always_comb begin
    counted   = (fdigit != 4'd0) || zv;
    ends      = (step == STEP_W'(MAX_FRAC_DIGITS - 1)) || (counted && prec_left == 8'd1);
    emit_now  = (gcnt == P_CNT - 1'b1) || ends;
    fstep     = (state == S_FRAC) && (!emit_now || out_free);
    gshift    = 4'd12 - {gcnt[1:0], 2'b00};
    newgrp    = grp | ({12'd0, fdigit} << gshift);
    prec_next = counted ? prec_left - 8'd1 : prec_left;
    skip_next = counted ? skip : skip + 1'b1;
    fcmd.load = (state == S_SETUP) && !is_special;
    fcmd.step = fstep;
  end

  // output register takes a new item this cycle
  assign out_load = ((state == S_SETUP) && is_special && out_free) ||
                    ((state == S_INT) && out_free) ||
                    (fstep && emit_now);

  fed_dabble u_dabble (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dcmd),
    .bin_init (bin_init),
    .stat     (dstat),
    .bcd      (dab_bcd)
  );

  fed_frac_unit u_frac (
    .clk       (clk),
    .cmd       (fcmd),
    .frac_init (frac_init),
    .digit     (fdigit)
  );

  assign s_tready = (state == S_IDLE);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      prec_left <= '0;
      zv        <= 1'b0;
      skip      <= '0;
      step      <= '0;
      gcnt      <= '0;
      rem       <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_bits <= s_tdata[31:0];
            in_prec <= s_tdata[39:32];
            in_lzv  <= s_tdata[40];
            state   <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (is_special) begin
            if (out_free) begin
              m_tlast  <= 1'b1;
              if (mant_f == 23'd0) begin
                m_tuser <= fed_pkg::KIND_INF;
                m_tdata <= '0;
              end else begin
                m_tuser <= fed_pkg::KIND_NAN;
                m_tdata <= {6'd0, mant_f, 3'd0, 16'd0};
              end
              state <= S_IDLE;
            end
          end else begin
            prec_left <= in_prec;
            zv        <= in_lzv | int_nz;
            skip      <= '0;
            step      <= '0;
            grp       <= '0;
            gcnt      <= '0;
            state     <= S_CONV;
          end
        end
        S_CONV: begin
          if (!dstat.busy) begin
            emit  <= aligned;
            rem   <= dstat.total;
            state <= S_INT;
          end
        end
        S_INT: begin
          if (out_free) begin
            m_tuser  <= fed_pkg::KIND_INT;
            m_tlast  <= int_fin && (prec_left == 8'd0);
            m_tdata  <= {6'd0, 23'd0, int_cnt,
                         emit[fed_pkg::BCD_BITS-1 -: fed_pkg::GROUP_BITS] & GMASK};
            emit     <= emit << GRP_BITS;
            rem      <= rem - fed_pkg::DIGIT_CNT_W'(int_cnt);
            if (int_fin) begin
              state <= (prec_left == 8'd0) ? S_IDLE : S_FRAC;
            end
          end
        end
        S_FRAC: begin
          if (fstep) begin
            prec_left <= prec_next;
            zv        <= zv | counted;
            skip      <= skip_next;
            step      <= step + 1'b1;
            if (emit_now) begin
              m_tuser  <= fed_pkg::KIND_FRAC;
              m_tlast  <= ends;
              m_tdata  <= {ends ? skip_next : 6'd0, 23'd0, gcnt + 1'b1, newgrp};
              grp      <= '0;
              gcnt     <= '0;
            end else begin
              grp  <= newgrp;
              gcnt <= gcnt + 1'b1;
            end
            if (ends) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // an accepted item closes the input straight away
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in work");

  // special results are single and carry no digits
  a_special: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == fed_pkg::KIND_INF || m_tuser == fed_pkg::KIND_NAN))
      |-> (m_tlast && m_tdata[18:16] == 3'd0 && m_tdata[15:0] == 16'd0))
    else $error("special result with digits or without last");

  // digit results hold one to a full group of digits
  a_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == fed_pkg::KIND_INT || m_tuser == fed_pkg::KIND_FRAC))
      |-> (m_tdata[18:16] != 3'd0 && m_tdata[18:16] <= P_CNT))
    else $error("digit count out of range");

  // the skipped zero count rides only on the final result
  a_lzc: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[47:42] == 6'd0))
    else $error("leading zero count on a result that is not last");

endmodule

>>> tb/float_to_exact_decimal_digits_tb.sv
// testbench for the exact float to decimal digit block, checked against its own digit predictor
`timescale 1ns / 1ps

module float_to_exact_decimal_digits_tb;

  localparam int FRAC_LIMIT     = fed_pkg::MAX_FRAC_DIGITS_DEF;
  localparam int GROUP_DIGITS   = fed_pkg::DIGITS_PER_RESULT_DEF;
  localparam int RANDOM_ITEMS   = 420;
  localparam int LIMIT_CYCLES   = 2_000_000;
  localparam int TAIL_CYCLES    = 200;
  localparam int DIRECTED_ROWS  = 24;

  // one digit group as it leaves the block
  typedef struct {
    fed_pkg::kind_t                kind;
    logic [fed_pkg::GROUP_BITS-1:0] group;
    logic [fed_pkg::COUNT_W-1:0]    count;
    logic [fed_pkg::PAYLOAD_W-1:0]  payload;
    logic [fed_pkg::LZC_W-1:0]      lzc;
    logic                           last;
  } digit_group_t;

  // one stimulus row; typed rows carry their single expected group
  typedef struct packed {
    logic [31:0]                    bits;
    logic [7:0]                     prec;
    logic                           lzv;
    logic                           typed;
    fed_pkg::kind_t                 kind;
    logic [fed_pkg::GROUP_BITS-1:0] group;
    logic [fed_pkg::COUNT_W-1:0]    count;
    logic [fed_pkg::PAYLOAD_W-1:0]  payload;
  } float_row_t;

  localparam float_row_t DIRECTED [DIRECTED_ROWS] = '{
    // infinity, both signs
    '{32'h7F800000, 8'd10,  1'b0, 1'b1, fed_pkg::KIND_INF, 16'h0000, 3'd0, 23'h000000},
    '{32'hFF800000, 8'd0,   1'b1, 1'b1, fed_pkg::KIND_INF, 16'h0000, 3'd0, 23'h000000},
    // nan with largest and smallest payload
    '{32'h7FFFFFFF, 8'd255, 1'b0, 1'b1, fed_pkg::KIND_NAN, 16'h0000, 3'd0, 23'h7FFFFF},
    '{32'hFF800001, 8'd7,   1'b1, 1'b1, fed_pkg::KIND_NAN, 16'h0000, 3'd0, 23'h000001},
    // zero and one with no fraction digits
    '{32'h00000000, 8'd0,   1'b0, 1'b1, fed_pkg::KIND_INT, 16'h0000, 3'd1, 23'h000000},
    '{32'h80000000, 8'd0,   1'b1, 1'b1, fed_pkg::KIND_INT, 16'h0000, 3'd1, 23'h000000},
    '{32'h3F800000, 8'd0,   1'b0, 1'b1, fed_pkg::KIND_INT, 16'h1000, 3'd1, 23'h000000},
    // zero with fraction zeros skipped or counted
    '{32'h00000000, 8'd5,   1'b0, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'h00000000, 8'd3,   1'b1, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'h00000000, 8'd255, 1'b1, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    // denormals and the smallest normal
    '{32'h00000001, 8'd255, 1'b0, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'h00000001, 8'd255, 1'b1, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'h007FFFFF, 8'd20,  1'b0, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'h00800000, 8'd8,   1'b0, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    // largest exponent, most groups per item
    '{32'h7F7FFFFF, 8'd255, 1'b0, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'h7F7FFFFF, 8'd0,   1'b0, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'hFF7FFFFF, 8'd50,  1'b1, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    // ordinary fractions and integers
    '{32'h3DCCCCCD, 8'd8,   1'b0, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'h3A83126F, 8'd6,   1'b0, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'h3A83126F, 8'd6,   1'b1, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'h3FC00000, 8'd1,   1'b0, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'h4640E400, 8'd4,   1'b0, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'h4B800000, 8'd3,   1'b0, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000},
    '{32'h3F7FFFFF, 8'd255, 1'b0, 1'b0, fed_pkg::KIND_INT, 16'h0000, 3'd0, 23'h000000}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  float_row_t   row_now;
  digit_group_t pending_groups[$];
  int           error_count = 0;
  int           items_taken = 0;
  int           groups_checked = 0;
  int           specials_taken = 0;
  int           cycle_count = 0;

  float_to_exact_decimal_digits dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // exact digit expansion of one float, queued as digit groups
  task automatic expand_float(input logic [31:0] bits, input logic [7:0] prec,
                              input logic lzv);
    logic [7:0]                     expo;
    logic [23:0]                    mant;
    logic [287:0]                   placed;
    logic [127:0]                   ipart;
    logic [159:0]                   fpart;
    logic [163:0]                   prod;
    logic [3:0]                     idig [fed_pkg::INT_DIGITS];
    logic [3:0]                     fdig [FRAC_LIMIT];
    logic [7:0]                     left;
    logic [fed_pkg::LZC_W-1:0]      skipped;
    logic [fed_pkg::GROUP_BITS-1:0] g;
    logic                           seen;
    logic                           fin;
    int                             sh, ni, nf, i, k, n;
    digit_group_t                   res;

    expo = bits[30:23];
    mant = {1'b0, bits[22:0]};
    if (expo == 8'hFF) begin
      res.kind    = (bits[22:0] == '0) ? fed_pkg::KIND_INF : fed_pkg::KIND_NAN;
      res.group   = '0;
      res.count   = '0;
      res.payload = (bits[22:0] == '0) ? '0 : bits[22:0];
      res.lzc     = '0;
      res.last    = 1'b1;
      pending_groups.push_back(res);
      return;
    end

    // place the mantissa lsb at bit (exp - 23) + 160
    if (expo == 8'd0) begin
      sh = 11;
    end else begin
      mant[23] = 1'b1;
      sh = int'(expo) + 10;
    end
    placed = 288'(mant) << sh;
    ipart  = placed[287:160];
    fpart  = placed[159:0];
    seen   = lzv;
    left   = prec;

    // integer digits, least significant first
    ni = 0;
    do begin
      idig[ni] = 4'(ipart % 128'd10);
      ipart    = ipart / 128'd10;
      if (idig[ni] != 4'd0) seen = 1'b1;
      ni++;
    end while (ipart != '0);

    // fraction digits; leading zeros skipped until something is seen
    nf = 0;
    skipped = '0;
    while (nf < FRAC_LIMIT && left != 8'd0) begin
      prod     = 164'(fpart) * 164'd10;
      fdig[nf] = prod[163:160];
      fpart    = prod[159:0];
      if (fdig[nf] != 4'd0 || seen) begin
        left = left - 8'd1;
        seen = 1'b1;
      end else begin
        skipped = skipped + 1'b1;
      end
      nf++;
    end

    // integer groups, most significant digit first
    for (i = 0; i < ni; i += GROUP_DIGITS) begin
      n = (ni - i > GROUP_DIGITS) ? GROUP_DIGITS : ni - i;
      g = '0;
      for (k = 0; k < n; k++) g[15 - 4 * k -: 4] = idig[ni - 1 - (i + k)];
      fin = (i + n >= ni) && (nf == 0);
      res.kind    = fed_pkg::KIND_INT;
      res.group   = g;
      res.count   = fed_pkg::COUNT_W'(n);
      res.payload = '0;
      res.lzc     = fin ? skipped : '0;
      res.last    = fin;
      pending_groups.push_back(res);
    end

    // fraction groups in order of generation
    for (i = 0; i < nf; i += GROUP_DIGITS) begin
      n = (nf - i > GROUP_DIGITS) ? GROUP_DIGITS : nf - i;
      g = '0;
      for (k = 0; k < n; k++) g[15 - 4 * k -: 4] = fdig[i + k];
      fin = (i + n >= nf);
      res.kind    = fed_pkg::KIND_FRAC;
      res.group   = g;
      res.count   = fed_pkg::COUNT_W'(n);
      res.payload = '0;
      res.lzc     = fin ? skipped : '0;
      res.last    = fin;
      pending_groups.push_back(res);
    end
  endtask

  // output checking first, then queue what the newly taken item will produce
  always @(posedge clk) begin
    digit_group_t want;
    digit_group_t typed_res;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_groups.size() == 0) begin
        $error("unexpected digit group: kind %0d group %h", m_tuser, m_tdata[15:0]);
        error_count++;
      end else begin
        want = pending_groups.pop_front();
        groups_checked++;
        if (m_tuser != want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, m_tuser);
          error_count++;
        end
        if (m_tdata[15:0] != want.group) begin
          $error("digit_group: expected %h, actual %h", want.group, m_tdata[15:0]);
          error_count++;
        end
        if (m_tdata[18:16] != want.count) begin
          $error("digit_count: expected %0d, actual %0d", want.count, m_tdata[18:16]);
          error_count++;
        end
        if (m_tdata[41:19] != want.payload) begin
          $error("nan_payload: expected %h, actual %h", want.payload, m_tdata[41:19]);
          error_count++;
        end
        if (m_tdata[47:42] != want.lzc) begin
          $error("lead_zero_count: expected %0d, actual %0d", want.lzc, m_tdata[47:42]);
          error_count++;
        end
        if (m_tlast != want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_tlast);
          error_count++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      items_taken++;
      if (s_tdata[30:23] == 8'hFF) specials_taken++;
      if (row_now.typed) begin
        typed_res.kind    = row_now.kind;
        typed_res.group   = row_now.group;
        typed_res.count   = row_now.count;
        typed_res.payload = row_now.payload;
        typed_res.lzc     = '0;
        typed_res.last    = 1'b1;
        pending_groups.push_back(typed_res);
      end else begin
        expand_float(s_tdata[31:0], s_tdata[39:32], s_tdata[40]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d groups pending", cycle_count,
               pending_groups.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: ready runs broken by random stalls, now and then a long clean run
  initial begin
    int run;
    int gap;
    m_tready = 1'b0;
    forever begin
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(150, 300) : $urandom_range(1, 12);
      repeat (run) @(negedge clk) m_tready <= 1'b1;
      gap = pick_gap();
      repeat (gap) @(negedge clk) m_tready <= 1'b0;
    end
  end

  // offer one item and hold it until taken
  task automatic offer_item(input float_row_t row);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, row.lzv, row.prec, row.bits};
    row_now  <= row;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_groups.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    float_row_t row;
    int         i, r;
    logic [7:0] expo;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    row_now = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed rows
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      offer_item(DIRECTED[i]);
      idle_sender(pick_gap());
    end

    // hold off until every directed group has come out
    idle_sender(1);
    wait_drained();

    // random items by class of exponent
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      row = '0;
      r = $urandom_range(0, 99);
      if (r < 30) expo = 8'($urandom_range(0, 255));
      else if (r < 65) expo = 8'($urandom_range(100, 150));
      else if (r < 75) expo = 8'd0;
      else if (r < 85) expo = 8'($urandom_range(200, 254));
      else if (r < 92) expo = 8'hFF;
      else expo = 8'($urandom_range(127, 150));
      row.bits = {1'($urandom_range(0, 1)), expo, 23'($urandom)};
      // few mantissa bits: exact integers and short fractions
      if (r >= 92) row.bits[15:0] = '0;
      if (expo == 8'd0 && $urandom_range(0, 3) == 0) row.bits[22:0] = 23'($urandom_range(0, 15));
      if (expo == 8'hFF && $urandom_range(0, 2) == 0) row.bits[22:0] = '0;

      r = $urandom_range(0, 99);
      if (r < 50) row.prec = 8'($urandom_range(0, 12));
      else if (r < 80) row.prec = 8'($urandom_range(13, 60));
      else if (r < 90) row.prec = 8'd0;
      else row.prec = 8'($urandom_range(0, 255));
      row.lzv = 1'($urandom_range(0, 1));

      offer_item(row);
      if (i == RANDOM_ITEMS / 2) begin
        idle_sender(1);
        wait_drained();
      end else if (i < 300 || i >= 340) begin
        idle_sender(pick_gap());
      end
    end

    idle_sender(1);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d floats (%0d directed, %0d infinity or nan), %0d groups compared",
             items_taken, DIRECTED_ROWS, specials_taken, groups_checked);
    $display("ready and valid gaps random on both sides, %0d mismatches", error_count);
    if (error_count == 0 && pending_groups.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fed_pkg.sv
rtl/fed_dabble.sv
rtl/fed_frac_unit.sv
rtl/float_to_exact_decimal_digits.sv
tb/float_to_exact_decimal_digits_tb.sv
